@@ sv/lsqs_pkg.sv @@
`default_nettype none

package lsqs_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned QRAW_W  = 8;
  localparam int unsigned COV_W   = 9;

  // Degree buckets over one revolution
  localparam int unsigned          BUCKETS     = 360;
  localparam int unsigned          BKT_W       = 9;
  localparam logic [BKT_W-1:0]     LAST_BUCKET = BKT_W'(BUCKETS - 1);

  // Scale for the valid-ratio check
  localparam logic [9:0] PERMILLE_SCALE = 10'd1000;

  // Output record queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Configuration register reset values
  localparam logic [17:0] RST_MIN_DIST   = 18'd200;
  localparam logic [17:0] RST_MAX_DIST   = 18'd48000;
  localparam logic [7:0]  RST_WARMUP     = 8'd3;
  localparam logic [13:0] RST_MIN_POINTS = 14'd100;
  localparam logic [8:0]  RST_MIN_COV    = 9'd270;
  localparam logic [9:0]  RST_MIN_RATIO  = 10'd100;

  typedef enum logic [2:0] {
    CFG_MIN_DIST   = 3'd0,
    CFG_MAX_DIST   = 3'd1,
    CFG_WARMUP     = 3'd2,
    CFG_MIN_POINTS = 3'd3,
    CFG_MIN_COV    = 3'd4,
    CFG_MIN_RATIO  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_OK           = 2'd0,
    VERDICT_FEW_POINTS   = 2'd1,
    VERDICT_LOW_COVERAGE = 2'd2,
    VERDICT_LOW_RATIO    = 2'd3
  } verdict_e;

  typedef enum logic {
    REC_FRAME = 1'b0,
    REC_RUN   = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic [17:0] min_dist;
    logic [17:0] max_dist;
    logic [7:0]  warmup;
    logic [13:0] min_points;
    logic [8:0]  min_cov;
    logic [9:0]  min_ratio;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_q14;
    logic [DIST_W-1:0]  distance_q2;
    logic [QRAW_W-1:0]  quality_raw;
    logic               has_point;
    logic               end_of_frame;
    logic               end_of_run;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       point_count;
    logic [31:0]       valid_count;
    logic [DIST_W-1:0] nearest_q2;
    logic [DIST_W-1:0] farthest_q2;
    logic [47:0]       distance_total;
    logic [31:0]       quality_total;
    logic [COV_W-1:0]  covered_degrees;
  } stats_t;

  // Records leaving the accumulator, before the verdict is known
  typedef struct packed {
    logic        frame_vld;
    stats_t      frame;
    logic        run_vld;
    stats_t      run;
    logic [15:0] counted_frames;
  } stage_t;

  // Records ready to be written into the output queue
  typedef struct packed {
    logic     frame_vld;
    stats_t   frame;
    logic     run_vld;
    stats_t   run;
    verdict_e verdict;
  } push_t;

  typedef struct packed {
    rec_kind_e kind;
    stats_t    stats;
    verdict_e  verdict;
    logic      done;
  } out_rec_t;

endpackage

`default_nettype wire

@@ sv/lsqs_accum.sv @@
`default_nettype none

module lsqs_accum
  import lsqs_pkg::*;
#(
  parameter int unsigned MAX_FRAME_POINTS = 8192,
  parameter int unsigned QUALITY_SHIFT    = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output stage_t   stage_o
);

  localparam int unsigned     FP_W      = $clog2(MAX_FRAME_POINTS + 1);
  localparam int unsigned     QW        = QRAW_W - QUALITY_SHIFT;
  localparam logic [FP_W-1:0] FRAME_CAP = FP_W'(MAX_FRAME_POINTS);

  // Frame and run state
  logic [7:0]         frame_number_q, frame_number_d;
  logic [15:0]        counted_frames_q, counted_frames_d;
  logic [FP_W-1:0]    frame_points_q, frame_points_d;
  logic [FP_W-1:0]    frame_valid_q, frame_valid_d;
  logic [DIST_W-1:0]  frame_nearest_q, frame_nearest_d;
  logic [DIST_W-1:0]  frame_farthest_q, frame_farthest_d;
  logic [31:0]        frame_dsum_q, frame_dsum_d;
  logic [19:0]        frame_qsum_q, frame_qsum_d;
  logic [31:0]        run_points_q, run_points_d;
  logic [31:0]        run_valid_q, run_valid_d;
  logic [DIST_W-1:0]  run_nearest_q, run_nearest_d;
  logic [DIST_W-1:0]  run_farthest_q, run_farthest_d;
  logic [47:0]        run_dsum_q, run_dsum_d;
  logic [31:0]        run_qsum_q, run_qsum_d;
  logic [BUCKETS-1:0] seen_q, seen_d;
  logic [COV_W-1:0]   seen_count_q, seen_count_d;
  stage_t             stage_q, stage_d;

  // Per-point terms
  logic [QW-1:0]     qual;
  logic              counted, take, in_band, good, new_bucket;
  logic              eof, eor;
  logic [22:0]       angle_x90;
  logic [BKT_W-1:0]  bucket_raw, bucket;
  logic [32:0]       fds_sum;
  logic [20:0]       fqs_sum;
  logic [48:0]       rds_sum;
  logic [32:0]       rqs_sum;

  // Values after the point, before any end-of-frame or end-of-run clear
  logic [FP_W-1:0]   fp1, fv1;
  logic [DIST_W-1:0] fn1, ff1, rn1, rf1;
  logic [31:0]       fds1, rp1, rv1, rqs1;
  logic [19:0]       fqs1;
  logic [47:0]       rds1;
  logic [COV_W-1:0]  sc1;
  logic [15:0]       cf1;
  logic [7:0]        fnum1;

  always_comb begin
    qual       = item_i.quality_raw[QRAW_W-1:QUALITY_SHIFT];
    counted    = frame_number_q >= cfg_i.warmup;
    take       = fire_i && item_i.has_point && counted && (frame_points_q < FRAME_CAP);
    in_band    = (item_i.distance_q2 >= cfg_i.min_dist) &&
                 (item_i.distance_q2 <= cfg_i.max_dist);
    good       = take && in_band && (qual != '0);
    eor        = fire_i && item_i.end_of_run;
    eof        = fire_i && (item_i.end_of_frame || item_i.end_of_run);

    // Bucket = angle * 90 >> 14, built from shifts
    angle_x90  = {1'b0, item_i.angle_q14, 6'b0} + {3'b0, item_i.angle_q14, 4'b0} +
                 {4'b0, item_i.angle_q14, 3'b0} + {6'b0, item_i.angle_q14, 1'b0};
    bucket_raw = angle_x90[22:14];
    bucket     = (bucket_raw > LAST_BUCKET) ? LAST_BUCKET : bucket_raw;
    new_bucket = good && !seen_q[bucket];

    // Saturating sums
    fds_sum = {1'b0, frame_dsum_q} + 33'(item_i.distance_q2);
    fqs_sum = {1'b0, frame_qsum_q} + 21'(qual);
    rds_sum = {1'b0, run_dsum_q} + 49'(item_i.distance_q2);
    rqs_sum = {1'b0, run_qsum_q} + 33'(qual);

    fp1  = take ? frame_points_q + 1'b1 : frame_points_q;
    fv1  = good ? frame_valid_q + 1'b1 : frame_valid_q;
    fn1  = (good && item_i.distance_q2 < frame_nearest_q) ? item_i.distance_q2
                                                          : frame_nearest_q;
    ff1  = (good && item_i.distance_q2 > frame_farthest_q) ? item_i.distance_q2
                                                           : frame_farthest_q;
    rn1  = (good && item_i.distance_q2 < run_nearest_q) ? item_i.distance_q2
                                                        : run_nearest_q;
    rf1  = (good && item_i.distance_q2 > run_farthest_q) ? item_i.distance_q2
                                                         : run_farthest_q;
    fds1 = !good ? frame_dsum_q : (fds_sum[32] ? '1 : fds_sum[31:0]);
    fqs1 = !good ? frame_qsum_q : (fqs_sum[20] ? '1 : fqs_sum[19:0]);
    rds1 = !good ? run_dsum_q : (rds_sum[48] ? '1 : rds_sum[47:0]);
    rqs1 = !good ? run_qsum_q : (rqs_sum[32] ? '1 : rqs_sum[31:0]);
    rp1  = (take && run_points_q != '1) ? run_points_q + 1'b1 : run_points_q;
    rv1  = (good && run_valid_q != '1) ? run_valid_q + 1'b1 : run_valid_q;
    sc1  = new_bucket ? seen_count_q + 1'b1 : seen_count_q;

    // Frame bookkeeping at the end of a frame
    cf1   = (eof && counted && counted_frames_q != '1) ? counted_frames_q + 1'b1
                                                       : counted_frames_q;
    fnum1 = (eof && !counted && frame_number_q != '1) ? frame_number_q + 1'b1
                                                      : frame_number_q;
  end

  // Records caused by this item
  always_comb begin
    stage_d.frame_vld             = eof && counted;
    stage_d.frame.point_count     = 32'(fp1);
    stage_d.frame.valid_count     = 32'(fv1);
    stage_d.frame.nearest_q2      = (fv1 != '0) ? fn1 : '0;
    stage_d.frame.farthest_q2     = (fv1 != '0) ? ff1 : '0;
    stage_d.frame.distance_total  = 48'(fds1);
    stage_d.frame.quality_total   = 32'(fqs1);
    stage_d.frame.covered_degrees = sc1;
    stage_d.run_vld               = eor;
    stage_d.run.point_count       = rp1;
    stage_d.run.valid_count       = rv1;
    stage_d.run.nearest_q2        = (rv1 != '0) ? rn1 : '0;
    stage_d.run.farthest_q2       = (rv1 != '0) ? rf1 : '0;
    stage_d.run.distance_total    = rds1;
    stage_d.run.quality_total     = rqs1;
    stage_d.run.covered_degrees   = sc1;
    stage_d.counted_frames        = cf1;
  end

  // Next state: point update, then frame clear, then run clear
  always_comb begin
    frame_number_d   = fnum1;
    counted_frames_d = cf1;
    frame_points_d   = fp1;
    frame_valid_d    = fv1;
    frame_nearest_d  = fn1;
    frame_farthest_d = ff1;
    frame_dsum_d     = fds1;
    frame_qsum_d     = fqs1;
    run_points_d     = rp1;
    run_valid_d      = rv1;
    run_nearest_d    = rn1;
    run_farthest_d   = rf1;
    run_dsum_d       = rds1;
    run_qsum_d       = rqs1;
    seen_count_d     = sc1;
    seen_d           = seen_q;
    if (new_bucket) begin
      seen_d[bucket] = 1'b1;
    end
    if (eof) begin
      frame_points_d   = '0;
      frame_valid_d    = '0;
      frame_nearest_d  = '1;
      frame_farthest_d = '0;
      frame_dsum_d     = '0;
      frame_qsum_d     = '0;
    end
    if (eor) begin
      frame_number_d   = '0;
      counted_frames_d = '0;
      run_points_d     = '0;
      run_valid_d      = '0;
      run_nearest_d    = '1;
      run_farthest_d   = '0;
      run_dsum_d       = '0;
      run_qsum_d       = '0;
      seen_count_d     = '0;
      seen_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_number_q   <= '0;
      counted_frames_q <= '0;
      frame_points_q   <= '0;
      frame_valid_q    <= '0;
      frame_nearest_q  <= '1;
      frame_farthest_q <= '0;
      frame_dsum_q     <= '0;
      frame_qsum_q     <= '0;
      run_points_q     <= '0;
      run_valid_q      <= '0;
      run_nearest_q    <= '1;
      run_farthest_q   <= '0;
      run_dsum_q       <= '0;
      run_qsum_q       <= '0;
      seen_q           <= '0;
      seen_count_q     <= '0;
      stage_q          <= '0;
    end else begin
      frame_number_q   <= frame_number_d;
      counted_frames_q <= counted_frames_d;
      frame_points_q   <= frame_points_d;
      frame_valid_q    <= frame_valid_d;
      frame_nearest_q  <= frame_nearest_d;
      frame_farthest_q <= frame_farthest_d;
      frame_dsum_q     <= frame_dsum_d;
      frame_qsum_q     <= frame_qsum_d;
      run_points_q     <= run_points_d;
      run_valid_q      <= run_valid_d;
      run_nearest_q    <= run_nearest_d;
      run_farthest_q   <= run_farthest_d;
      run_dsum_q       <= run_dsum_d;
      run_qsum_q       <= run_qsum_d;
      seen_q           <= seen_d;
      seen_count_q     <= seen_count_d;
      stage_q          <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ sv/lsqs_verdict.sv @@
`default_nettype none

module lsqs_verdict
  import lsqs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  input  cfg_t   cfg_i,
  output push_t  push_o
);

  stage_t      s3_q;
  logic [29:0] need_valid_q;
  logic [41:0] valid_scaled_q;
  logic [41:0] need_scaled_q;
  logic        few_points, low_coverage, low_ratio;
  verdict_e    verdict;

  // Record copy; its valid bits are control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= stage_i;
    end
  end

  // Products for the pass checks, one multiplier each
  always_ff @(posedge clk_i) begin
    need_valid_q   <= 30'(cfg_i.min_points) * 30'(stage_i.counted_frames);
    valid_scaled_q <= 42'(stage_i.run.valid_count) * 42'(PERMILLE_SCALE);
    need_scaled_q  <= 42'(cfg_i.min_ratio) * 42'(stage_i.run.point_count);
  end

  // Pass code, checked in priority order
  always_comb begin
    if (s3_q.counted_frames == '0) begin
      few_points = cfg_i.min_points != '0;
    end else begin
      few_points = s3_q.run.valid_count < {2'b0, need_valid_q};
    end
    low_coverage = s3_q.run.covered_degrees < cfg_i.min_cov;
    if (s3_q.run.point_count == '0) begin
      low_ratio = cfg_i.min_ratio != '0;
    end else begin
      low_ratio = valid_scaled_q < need_scaled_q;
    end
    if (few_points) begin
      verdict = VERDICT_FEW_POINTS;
    end else if (low_coverage) begin
      verdict = VERDICT_LOW_COVERAGE;
    end else if (low_ratio) begin
      verdict = VERDICT_LOW_RATIO;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    push_o.frame_vld = s3_q.frame_vld;
    push_o.frame     = s3_q.frame;
    push_o.run_vld   = s3_q.run_vld;
    push_o.run       = s3_q.run;
    push_o.verdict   = verdict;
  end

endmodule

`default_nettype wire

@@ sv/lidar_scan_quality_stats_unit.sv @@
// A word passes the input register, the accumulator and verdict stages, then the record queue.
// Throughput: one input word per cycle; a word that closes a counted frame and a run
// yields two records, which leave one at a time through an 8-entry record queue.
// The input stalls only when that queue, with records still in flight, lacks room for two.
// Reset: all frame and run state, the bucket map and the queue clear at once; the
// configuration registers return to their defaults. No clearing pass is needed.
`default_nettype none

module lidar_scan_quality_stats_unit
  import lsqs_pkg::*;
#(
  parameter int unsigned MAX_FRAME_POINTS = 8192,
  parameter int unsigned QUALITY_SHIFT    = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [17:0]  cfg_data_i,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [47:0]  s_axis_tdata_i,  // angle_q14, distance_q2, quality_raw, zero pad
  input  logic         s_axis_tlast_i,  // end_of_frame
  input  logic [1:0]   s_axis_tuser_i,  // has_point, end_of_run
  // Output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // point_count, valid_count, nearest_q2, farthest_q2, distance_total, quality_total,
  // covered_degrees, verdict, zero pad
  output logic [191:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,  // run_done
  output logic         m_axis_tuser_o   // record_kind
);

  localparam int unsigned PEND_W = CNT_W + 1;

  cfg_t            cfg_q;
  logic            s1_vld_q, s1_vld_d;
  in_item_t        s1_item_q;
  logic            in_accept, s1_fire;
  stage_t          stage;
  push_t           push;
  out_rec_t        fifo_q [FIFO_DEPTH];
  out_rec_t        frame_rec, run_rec, head;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] stage_n, push_n;
  logic [PEND_W-1:0] pending;
  logic            pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist   <= RST_MIN_DIST;
      cfg_q.max_dist   <= RST_MAX_DIST;
      cfg_q.warmup     <= RST_WARMUP;
      cfg_q.min_points <= RST_MIN_POINTS;
      cfg_q.min_cov    <= RST_MIN_COV;
      cfg_q.min_ratio  <= RST_MIN_RATIO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_DIST:   cfg_q.min_dist   <= cfg_data_i;
        CFG_MAX_DIST:   cfg_q.max_dist   <= cfg_data_i;
        CFG_WARMUP:     cfg_q.warmup     <= cfg_data_i[7:0];
        CFG_MIN_POINTS: cfg_q.min_points <= cfg_data_i[13:0];
        CFG_MIN_COV:    cfg_q.min_cov    <= cfg_data_i[8:0];
        CFG_MIN_RATIO:  cfg_q.min_ratio  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Records already committed to land in the queue
  always_comb begin
    stage_n = CNT_W'(stage.frame_vld) + CNT_W'(stage.run_vld);
    push_n  = CNT_W'(push.frame_vld) + CNT_W'(push.run_vld);
    pending = PEND_W'(count_q) + PEND_W'(stage_n) + PEND_W'(push_n);
  end

  // Input register: a word moves on when the queue can take its two records
  assign s1_fire         = s1_vld_q && (pending + PEND_W'(2) <= PEND_W'(FIFO_DEPTH));
  assign s_axis_tready_o = !s1_vld_q || s1_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.angle_q14    <= s_axis_tdata_i[15:0];
      s1_item_q.distance_q2  <= s_axis_tdata_i[33:16];
      s1_item_q.quality_raw  <= s_axis_tdata_i[41:34];
      s1_item_q.has_point    <= s_axis_tuser_i[0];
      s1_item_q.end_of_frame <= s_axis_tlast_i;
      s1_item_q.end_of_run   <= s_axis_tuser_i[1];
    end
  end

  lsqs_accum #(
    .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
    .QUALITY_SHIFT    (QUALITY_SHIFT)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .item_i  (s1_item_q),
    .cfg_i   (cfg_q),
    .stage_o (stage)
  );

  lsqs_verdict u_verdict (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .cfg_i   (cfg_q),
    .push_o  (push)
  );

  // Record queue: frame record first, then the run record
  always_comb begin
    frame_rec.kind    = REC_FRAME;
    frame_rec.stats   = push.frame;
    frame_rec.verdict = VERDICT_OK;
    frame_rec.done    = 1'b0;
    run_rec.kind      = REC_RUN;
    run_rec.stats     = push.run;
    run_rec.verdict   = push.verdict;
    run_rec.done      = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push.frame_vld) begin
      fifo_q[wr_ptr_q] <= frame_rec;
    end
    if (push.run_vld) begin
      fifo_q[wr_ptr_q + PTR_W'(push.frame_vld)] <= run_rec;
    end
  end

  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign count_d = count_q + push_n - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_d;
    end
  end

  // Output word
  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = count_q != '0;
  assign m_axis_tdata_o  = {1'b0, head.verdict, head.stats.covered_degrees,
                            head.stats.quality_total, head.stats.distance_total,
                            head.stats.farthest_q2, head.stats.nearest_q2,
                            head.stats.valid_count, head.stats.point_count};
  assign m_axis_tlast_o  = head.done;
  assign m_axis_tuser_o  = head.kind;

  // The credit check must keep the queue from ever overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PEND_W'(count_q) + PEND_W'(push_n) - PEND_W'(pop)) <= PEND_W'(FIFO_DEPTH))
    else $error("record queue overflow");

  // Only run records close a run
  a_done_is_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == m_axis_tuser_o))
    else $error("run_done and record kind disagree");

  // Frame records carry no pass code
  a_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[190:189] == VERDICT_OK))
    else $error("frame record with a pass code");

  // A word held back in the input register is neither lost nor altered
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_fire) |=> (s1_vld_q && $stable(s1_item_q)))
    else $error("stalled input word changed");

endmodule

`default_nettype wire

@@ dv/lsqs_stats_checker.sv @@
// Watches both streams and the register port of the scan statistics unit,
// works out the records each accepted word must produce and compares them
// with the records that leave the block.
module lsqs_stats_checker
  import lsqs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [17:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [47:0]  s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [191:0] m_axis_tdata_i,
  input  logic         m_axis_tlast_i,
  input  logic         m_axis_tuser_i,
  output int           pending_o,
  output int           fail_count_o
);

  // Block parameters at their defaults
  localparam int unsigned FRAME_CAP = 8192;
  localparam int unsigned Q_SHIFT   = 2;

  // Mirror of the configuration registers
  cfg_t cfg;

  // Frame and run accumulators
  logic [7:0]         frame_no;
  logic [15:0]        frames_counted;
  logic [13:0]        f_points;
  logic [13:0]        f_valid;
  logic [17:0]        f_near;
  logic [17:0]        f_far;
  logic [31:0]        f_dist;
  logic [19:0]        f_qual;
  logic [31:0]        r_points;
  logic [31:0]        r_valid;
  logic [17:0]        r_near;
  logic [17:0]        r_far;
  logic [47:0]        r_dist;
  logic [31:0]        r_qual;
  logic [BUCKETS-1:0] seen;
  logic [8:0]         seen_n;

  out_rec_t awaited_records[$];
  int       mismatch_count;

  function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b,
                                          input logic [47:0] top);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, top}) ? top : s[47:0];
  endfunction

  function automatic out_rec_t make_record(input rec_kind_e kind, input logic [31:0] pts,
                                           input logic [31:0] val, input logic [17:0] lo,
                                           input logic [17:0] hi, input logic [47:0] dsum,
                                           input logic [31:0] qsum, input verdict_e v,
                                           input logic done);
    out_rec_t r;
    r.kind                  = kind;
    r.stats.point_count     = pts;
    r.stats.valid_count     = val;
    // Extremes read as zero when nothing valid was seen.
    r.stats.nearest_q2      = (val == 0) ? '0 : lo;
    r.stats.farthest_q2     = (val == 0) ? '0 : hi;
    r.stats.distance_total  = dsum;
    r.stats.quality_total   = qsum;
    r.stats.covered_degrees = seen_n;
    r.verdict               = v;
    r.done                  = done;
    return r;
  endfunction

  // Append one record behind the ones already awaited.
  task automatic queue_record(input out_rec_t r);
    awaited_records.insert(awaited_records.size(), r);
  endtask

  task automatic clear_frame_state();
    f_points = '0;
    f_valid  = '0;
    f_near   = '1;
    f_far    = '0;
    f_dist   = '0;
    f_qual   = '0;
  endtask

  task automatic clear_run_state();
    clear_frame_state();
    frame_no       = '0;
    frames_counted = '0;
    r_points       = '0;
    r_valid        = '0;
    r_near         = '1;
    r_far          = '0;
    r_dist         = '0;
    r_qual         = '0;
    seen           = '0;
    seen_n         = '0;
  endtask

  // Fold one accepted word into the accumulators and queue its records.
  task automatic tally_word(input in_item_t w);
    logic        counted;
    logic        closes;
    logic [7:0]  q;
    int unsigned bkt;
    logic        few;
    logic        low;
    verdict_e    v;
    counted = frame_no >= cfg.warmup;
    closes  = w.end_of_frame || w.end_of_run;
    q       = w.quality_raw >> Q_SHIFT;

    if (w.has_point && counted && f_points < FRAME_CAP) begin
      f_points = f_points + 1'b1;
      r_points = 32'(sat_sum(48'(r_points), 48'd1, 48'hFFFF_FFFF));
      if (w.distance_q2 >= cfg.min_dist && w.distance_q2 <= cfg.max_dist && q != 0) begin
        bkt = (32'(w.angle_q14) * 90) >> 14;
        if (bkt > BUCKETS - 1) bkt = BUCKETS - 1;
        if (!seen[bkt]) begin
          seen[bkt] = 1'b1;
          seen_n    = seen_n + 1'b1;
        end
        f_valid = f_valid + 1'b1;
        r_valid = 32'(sat_sum(48'(r_valid), 48'd1, 48'hFFFF_FFFF));
        if (w.distance_q2 < f_near) f_near = w.distance_q2;
        if (w.distance_q2 > f_far)  f_far  = w.distance_q2;
        if (w.distance_q2 < r_near) r_near = w.distance_q2;
        if (w.distance_q2 > r_far)  r_far  = w.distance_q2;
        f_dist = 32'(sat_sum(48'(f_dist), 48'(w.distance_q2), 48'hFFFF_FFFF));
        f_qual = 20'(sat_sum(48'(f_qual), 48'(q), 48'hF_FFFF));
        r_dist = sat_sum(r_dist, 48'(w.distance_q2), 48'hFFFF_FFFF_FFFF);
        r_qual = 32'(sat_sum(48'(r_qual), 48'(q), 48'hFFFF_FFFF));
      end
    end

    // A frame ends on its own marker or with the run.
    if (closes) begin
      if (counted) begin
        queue_record(make_record(REC_FRAME, 32'(f_points), 32'(f_valid), f_near,
                                 f_far, 48'(f_dist), 32'(f_qual), VERDICT_OK, 1'b0));
        if (frames_counted != 16'hFFFF) frames_counted = frames_counted + 1'b1;
      end else if (frame_no != 8'hFF) begin
        frame_no = frame_no + 1'b1;
      end
      clear_frame_state();
    end

    // Run verdict: point count first, then coverage, then valid ratio.
    if (w.end_of_run) begin
      if (frames_counted == 0) few = cfg.min_points != 0;
      else few = 64'(r_valid) < 64'(cfg.min_points) * 64'(frames_counted);
      if (r_points == 0) low = cfg.min_ratio != 0;
      else low = 64'(r_valid) * 64'd1000 < 64'(cfg.min_ratio) * 64'(r_points);
      if (few) v = VERDICT_FEW_POINTS;
      else if (seen_n < cfg.min_cov) v = VERDICT_LOW_COVERAGE;
      else if (low) v = VERDICT_LOW_RATIO;
      else v = VERDICT_OK;
      queue_record(make_record(REC_RUN, r_points, r_valid, r_near, r_far,
                               r_dist, r_qual, v, 1'b1));
      clear_run_state();
    end
  endtask

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t word;
    out_rec_t want;
    if (!rst_ni) begin
      cfg.min_dist   = RST_MIN_DIST;
      cfg.max_dist   = RST_MAX_DIST;
      cfg.warmup     = RST_WARMUP;
      cfg.min_points = RST_MIN_POINTS;
      cfg.min_cov    = RST_MIN_COV;
      cfg.min_ratio  = RST_MIN_RATIO;
      clear_run_state();
      awaited_records.delete();
      mismatch_count = 0;
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MIN_DIST:   cfg.min_dist   = cfg_data_i;
          CFG_MAX_DIST:   cfg.max_dist   = cfg_data_i;
          CFG_WARMUP:     cfg.warmup     = cfg_data_i[7:0];
          CFG_MIN_POINTS: cfg.min_points = cfg_data_i[13:0];
          CFG_MIN_COV:    cfg.min_cov    = cfg_data_i[8:0];
          CFG_MIN_RATIO:  cfg.min_ratio  = cfg_data_i[9:0];
          default: ;
        endcase
      end

      // Accepted input word
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        word.angle_q14    = s_axis_tdata_i[15:0];
        word.distance_q2  = s_axis_tdata_i[33:16];
        word.quality_raw  = s_axis_tdata_i[41:34];
        word.has_point    = s_axis_tuser_i[0];
        word.end_of_frame = s_axis_tlast_i;
        word.end_of_run   = s_axis_tuser_i[1];
        tally_word(word);
      end

      // Accepted output word against the oldest awaited record
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (awaited_records.size() == 0) begin
          $error("record_kind: expected no record, got %0d", m_axis_tuser_i);
          mismatch_count++;
        end else begin
          want = awaited_records.pop_front();
          check_field("record_kind", want.kind, m_axis_tuser_i);
          check_field("point_count", want.stats.point_count, m_axis_tdata_i[31:0]);
          check_field("valid_count", want.stats.valid_count, m_axis_tdata_i[63:32]);
          check_field("nearest_q2", want.stats.nearest_q2, m_axis_tdata_i[81:64]);
          check_field("farthest_q2", want.stats.farthest_q2, m_axis_tdata_i[99:82]);
          check_field("distance_total", want.stats.distance_total, m_axis_tdata_i[147:100]);
          check_field("quality_total", want.stats.quality_total, m_axis_tdata_i[179:148]);
          check_field("covered_degrees", want.stats.covered_degrees,
                      m_axis_tdata_i[188:180]);
          check_field("verdict", want.verdict, m_axis_tdata_i[190:189]);
          check_field("run_done", want.done, m_axis_tlast_i);
        end
      end
    end
    pending_o    <= awaited_records.size();
    fail_count_o <= mismatch_count;
  end

endmodule

@@ dv/lidar_scan_quality_stats_unit_tb.sv @@
// Stimulus and verdict for the scan statistics unit; checking is done by
// the checker instance beside the block.
module lidar_scan_quality_stats_unit_tb;
  import lsqs_pkg::*;

  localparam int unsigned RANDOM_WORDS = 850;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         cfg_we   = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [17:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic [47:0]  s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic [1:0]   s_tuser  = '0;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [191:0] m_tdata;
  wire          m_tlast;
  wire          m_tuser;

  int           pending;
  int           fail_count;
  int unsigned  words_sent = 0;
  int unsigned  random_goal;
  logic         calm = 1'b0;
  logic [17:0]  band_lo = RST_MIN_DIST;
  logic [17:0]  band_hi = RST_MAX_DIST;

  always #5 clk_i = ~clk_i;

  lidar_scan_quality_stats_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  lsqs_stats_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // The receiver stalls at random except during calm stretches.
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 36);
  end

  function automatic in_item_t lidar_word(input logic hp, input logic [15:0] ang,
                                          input logic [17:0] dist_q2, input logic [7:0] q,
                                          input logic eof, input logic eor);
    in_item_t w;
    w.angle_q14    = ang;
    w.distance_q2  = dist_q2;
    w.quality_raw  = q;
    w.has_point    = hp;
    w.end_of_frame = eof;
    w.end_of_run   = eor;
    return w;
  endfunction

  // Mostly inside the valid band, with its edges and the rest of the range.
  function automatic logic [17:0] pick_distance();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 72 && band_lo <= band_hi) return 18'($urandom_range(band_hi, band_lo));
    if (roll < 78) return band_lo;
    if (roll < 84) return band_hi;
    if (roll < 88) return band_lo - 1'b1;
    if (roll < 92) return band_hi + 1'b1;
    return 18'($urandom);
  endfunction

  // Present one word, after a random gap, and hold it until it is taken.
  task automatic drive_word(input in_item_t w);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, w.quality_raw, w.distance_q2, w.angle_q14};
    s_tlast  <= w.end_of_frame;
    s_tuser  <= {w.end_of_run, w.has_point};
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
  endtask

  // Stop sending and wait until every awaited record has left the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [17:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [17:0] lo, input logic [17:0] hi,
                               input logic [17:0] warm, input logic [17:0] pts,
                               input logic [17:0] cov, input logic [17:0] ratio);
    settle();
    put_reg(CFG_MIN_DIST, lo);
    put_reg(CFG_MAX_DIST, hi);
    put_reg(CFG_WARMUP, warm);
    put_reg(CFG_MIN_POINTS, pts);
    put_reg(CFG_MIN_COV, cov);
    put_reg(CFG_MIN_RATIO, ratio);
    cfg_we  <= 1'b0;
    band_lo = lo;
    band_hi = hi;
  endtask

  // A run of frames with random points; each frame closes on a marker word
  // that may carry a point of its own, and the last one ends the run.
  task automatic random_run(input int unsigned frames, input int unsigned max_pts);
    int unsigned npts;
    logic        last;
    for (int unsigned f = 0; f < frames; f++) begin
      npts = $urandom_range(max_pts, 0);
      last = (f == frames - 1);
      for (int unsigned p = 0; p < npts; p++) begin
        drive_word(lidar_word($urandom_range(99) < 95, 16'($urandom), pick_distance(),
                              8'($urandom), 1'b0, 1'b0));
      end
      drive_word(lidar_word(1'($urandom), 16'($urandom), pick_distance(), 8'($urandom),
                            last ? 1'($urandom) : 1'b1, last));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset setting: a point and three markers
    // fill the warmup, so the following frame is the first one counted.
    drive_word(lidar_word(1'b1, 16'd0, 18'd1000, 8'hFF, 1'b0, 1'b0));
    repeat (3) drive_word(lidar_word(1'b0, 16'd0, 18'd0, 8'd0, 1'b1, 1'b0));
    // Band edges, points outside it, a quality that shifts to zero, and the
    // extremes of every field, then a word without a point.
    drive_word(lidar_word(1'b1, 16'h0000, 18'd200, 8'd4, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'hFFFF, 18'd48000, 8'hFF, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'h4000, 18'd199, 8'hFF, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'h8000, 18'd48001, 8'hFF, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'hC000, 18'd1000, 8'd3, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'h2000, 18'h3FFFF, 8'h80, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'h1000, 18'd0, 8'h40, 1'b0, 1'b0));
    drive_word(lidar_word(1'b0, 16'hFFFF, 18'h3FFFF, 8'hFF, 1'b0, 1'b0));
    drive_word(lidar_word(1'b1, 16'h1234, 18'd30000, 8'd100, 1'b1, 1'b0));
    // A counted frame with markers only, then a run end that closes a frame.
    drive_word(lidar_word(1'b0, 16'd0, 18'd0, 8'd0, 1'b1, 1'b0));
    drive_word(lidar_word(1'b1, 16'd5000, 18'd5000, 8'd50, 1'b0, 1'b1));
    // Empty runs: one that ends alone, one with both markers.
    drive_word(lidar_word(1'b0, 16'd0, 18'd0, 8'd0, 1'b0, 1'b1));
    drive_word(lidar_word(1'b0, 16'd0, 18'd0, 8'd0, 1'b1, 1'b1));

    // Random runs under changing settings.
    random_goal = words_sent + RANDOM_WORDS;
    while (words_sent < random_goal) begin
      case ($urandom_range(3))
        0: apply_setting(18'd0, 18'h3FFFF, 18'd0, 18'd0, 18'd0, 18'd0);
        1: apply_setting(18'h3FFFF, 18'd0, 18'($urandom_range(2)), 18'd8192, 18'd360,
                         18'd1000);
        default: apply_setting(18'($urandom_range(3000)), 18'($urandom_range(262143, 20000)),
                               18'($urandom_range(3)), 18'($urandom_range(30)),
                               18'($urandom_range(360)), 18'($urandom_range(1000)));
      endcase
      repeat ($urandom_range(4, 1)) begin
        random_run($urandom_range(6, 1), ($urandom_range(9) == 0) ? 120 : 12);
      end
    end

    // Longest warmup, sent as a calm stretch with no idling on either side:
    // the frame counter climbs to its top value before frames are counted.
    apply_setting(18'd200, 18'd48000, 18'd255, 18'd1, 18'd10, 18'd500);
    calm = 1'b1;
    repeat (258) drive_word(lidar_word(1'b0, 16'd0, 18'd0, 8'd0, 1'b1, 1'b0));
    random_run(2, 20);
    calm = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("lidar_scan_quality_stats_unit test passed");
    end else begin
      $display("lidar_scan_quality_stats_unit test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30_000_000;
    $display("lidar_scan_quality_stats_unit test failed");
    $finish;
  end

endmodule
